// File: src/cumulative_ack_scoreboard_core_defines.svh
// assertion macros for the cumulative ack scoreboard
`ifndef CUMULATIVE_ACK_SCOREBOARD_CORE_DEFINES_SVH
`define CUMULATIVE_ACK_SCOREBOARD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define CAS_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define CAS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`else
`define CAS_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg)
`define CAS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg)
`endif

`endif

// File: src/cas_pkg.sv
// shared types and constants for the cumulative ack scoreboard
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    // field widths
    localparam int SEG_W  = 11;
    localparam int FUNC_W = 2;

    // bitmap organization
    localparam int WORD_W   = 32;
    localparam int WORD_LOG = 5;

    // defaults
    localparam int             MAX_SEGMENTS_DEF = 1024;
    localparam logic [SEG_W-1:0] SEG_COUNT_RESET = 11'd1024;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_MARK  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_RSVD  = 2'd3
    } cas_func_t;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_QRY_RD,
        ST_QRY_EVAL,
        ST_CLEAR,
        ST_RESP
    } cas_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_mark;
        logic wr_mark;
        logic rd_scan;
        logic eval;
        logic sweep;
        logic load_out;
    } cas_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_mark_ok;
        logic scan_none;
        logic scan_more;
        logic sweep_last;
        logic out_free;
    } cas_status_t;

endpackage

`default_nettype wire

// File: src/cas_ctrl.sv
// controller state machine for the cumulative ack scoreboard
`timescale 1ns / 1ps
`default_nettype none

module cas_ctrl
    import cas_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [FUNC_W-1:0] in_func,
    output logic                   in_ready,
    input  wire cas_status_t       status,
    output cas_cmd_t               cmd
);

    cas_state_t state_reg;
    cas_state_t state_next;
    logic       accept;
    cas_func_t  func;

    assign func   = cas_func_t'(in_func);
    assign accept = in_valid && in_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_MARK:  state_next = status.in_mark_ok ? ST_MARK_RD : ST_RESP;
                        FUNC_QUERY: state_next = ST_QRY_RD;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_MARK_RD:  state_next = ST_MARK_WR;
            ST_MARK_WR:  state_next = ST_RESP;
            ST_QRY_RD:   state_next = status.scan_none ? ST_RESP : ST_QRY_EVAL;
            ST_QRY_EVAL: state_next = status.scan_more ? ST_QRY_RD : ST_RESP;
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT:     cmd.sweep = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = accept;
            end
            ST_MARK_RD:  cmd.rd_mark = 1'b1;
            ST_MARK_WR:  cmd.wr_mark = 1'b1;
            ST_QRY_RD:   cmd.rd_scan = !status.scan_none;
            ST_QRY_EVAL: cmd.eval = 1'b1;
            ST_CLEAR:    cmd.sweep = 1'b1;
            ST_RESP:     cmd.load_out = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/cas_datapath.sv
// bitmap memory, ack frontier, size register and result register
`timescale 1ns / 1ps
`default_nettype none

module cas_datapath
    import cas_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [FUNC_W-1:0] in_func,
    input  wire logic [SEG_W-1:0]  in_seg,
    input  wire logic              cfg_valid,
    input  wire logic [SEG_W-1:0]  cfg_data,
    input  wire cas_cmd_t          cmd,
    output cas_status_t            status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SEG_W-1:0]       out_ack,
    output logic                   out_ok
);

    localparam int ROWS    = (MAX_SEGMENTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FRONT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W   = (FRONT_W > SEG_W) ? FRONT_W : SEG_W;
    localparam int EXT_W   = CMP_W + 1;

    // bitmap storage, one word per row
    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rd_data_reg;

    logic [SEG_W-1:0]   seg_count_reg;
    logic [FRONT_W-1:0] frontier_reg;
    logic [FRONT_W-1:0] frontier_next;
    logic [ROW_W-1:0]   sweep_cnt_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic               ok_reg;
    logic               out_valid_reg;
    logic [SEG_W-1:0]   out_ack_reg;
    logic               out_ok_reg;

    logic [CMP_W-1:0]    eff_size;
    logic [CMP_W-1:0]    seg_m1;
    logic [CMP_W-1:0]    seg_m1_row;
    logic [ROW_W-1:0]    mark_row;
    logic [WORD_LOG-1:0] mark_off;
    logic [EXT_W-1:0]    front_ext;
    logic [EXT_W-1:0]    size_ext;
    logic [EXT_W-1:0]    front_row;
    logic [ROW_W-1:0]    scan_row;
    logic [WORD_LOG-1:0] scan_off;
    logic [WORD_W-1:0]   zeros;
    logic [WORD_W-1:0]   lowbit;
    logic [WORD_LOG-1:0] zero_pos;
    logic [EXT_W-1:0]    row_base;
    logic [EXT_W-1:0]    cand;
    logic [EXT_W-1:0]    new_front;
    logic                in_ok;
    logic                sweep_last;
    logic [ROW_W-1:0]    rd_addr;
    logic [ROW_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                wr_en;
    logic                rd_en;

    // effective size is the register clamped to the array size
    assign eff_size = (CMP_W'(seg_count_reg) > CMP_W'(MAX_SEGMENTS))
                      ? CMP_W'(MAX_SEGMENTS) : CMP_W'(seg_count_reg);
    assign size_ext = EXT_W'(eff_size);

    // range check on the incoming segment number
    assign in_ok = (in_seg != '0) && (CMP_W'(in_seg) <= eff_size);

    // mark addressing from the captured segment number
    assign seg_m1     = CMP_W'(seg_reg) - CMP_W'(1);
    assign seg_m1_row = seg_m1 >> WORD_LOG;
    assign mark_row   = seg_m1_row[ROW_W-1:0];
    assign mark_off   = seg_m1[WORD_LOG-1:0];

    // scan addressing from the frontier
    assign front_ext = EXT_W'(frontier_reg);
    assign front_row = front_ext >> WORD_LOG;
    assign scan_row  = front_row[ROW_W-1:0];
    assign scan_off  = front_ext[WORD_LOG-1:0];

    // first clear bit at or above the frontier offset
    assign zeros  = ~rd_data_reg & ({WORD_W{1'b1}} << scan_off);
    assign lowbit = zeros & (~zeros + WORD_W'(1));

    always_comb
    begin
        zero_pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (lowbit[i])
            begin
                zero_pos = zero_pos | WORD_LOG'(i);
            end
        end
    end

    assign row_base  = front_ext & ~EXT_W'(WORD_W - 1);
    assign cand      = row_base + ((zeros == '0) ? EXT_W'(WORD_W) : EXT_W'(zero_pos));
    assign new_front = (cand < size_ext) ? cand : size_ext;

    // frontier update
    always_comb
    begin
        frontier_next = frontier_reg;
        if (cmd.sweep)
        begin
            frontier_next = '0;
        end
        else if (cmd.eval)
        begin
            frontier_next = new_front[FRONT_W-1:0];
        end
    end

    assign sweep_last = (sweep_cnt_reg == ROW_W'(ROWS - 1));

    // memory port selection
    assign rd_en   = cmd.rd_mark || cmd.rd_scan;
    assign rd_addr = cmd.rd_mark ? mark_row : scan_row;
    assign wr_en   = cmd.sweep || cmd.wr_mark;
    assign wr_addr = cmd.sweep ? sweep_cnt_reg : mark_row;
    assign wr_data = cmd.sweep ? '0 : (rd_data_reg | (WORD_W'(1) << mark_off));

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= SEG_COUNT_RESET;
            frontier_reg  <= '0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seg_count_reg <= cfg_data;
            end
            frontier_reg <= frontier_next;
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + ROW_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // frontier masked to the result field
    function automatic logic [SEG_W-1:0] new_ack(input logic [FRONT_W-1:0] f);
        logic [CMP_W-1:0] wide;
        wide    = CMP_W'(f);
        new_ack = wide[SEG_W-1:0];
    endfunction

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seg_reg <= in_seg;
            case (cas_func_t'(in_func))
                FUNC_MARK:  ok_reg <= in_ok;
                FUNC_QUERY: ok_reg <= 1'b1;
                FUNC_CLEAR: ok_reg <= 1'b1;
                default:    ok_reg <= 1'b0;
            endcase
        end
        if (cmd.load_out)
        begin
            out_ack_reg <= new_ack(frontier_reg);
            out_ok_reg  <= ok_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        status            = '0;
        status.in_mark_ok = in_ok;
        status.scan_none  = (CMP_W'(frontier_reg) >= eff_size);
        status.scan_more  = (zeros == '0) && (cand < size_ext);
        status.sweep_last = sweep_last;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_ack   = out_ack_reg;
    assign out_ok    = out_ok_reg;

endmodule

`default_nettype wire

// File: src/cumulative_ack_scoreboard_core.sv
// top level of the cumulative ack scoreboard
// Single-flow received-segment scoreboard. Items arrive on the s_ stream:
// s_tuser carries the operation (mark, query, clear), s_tdata the 1-based
// segment number used by mark. Each item returns one transfer on the m_
// stream: m_tdata holds the cumulative ack, m_tuser the accepted flag.
// The user must write the segment_count register on the cfg_ channel only
// while idle; the block does not enforce it. Items are processed one at a
// time. Steps from accept to result valid:
//   mark in range: bitmap row read, then written back with the bit set;
//     other marks and reserved codes: result loaded directly
//   query: no row read when the frontier already reaches the size, else
//     each 32-bit row scanned is read, then searched for its first zero
//   clear: one memory row zeroed per cycle (ROWS = 32 at 1024)
// A new item is taken the cycle after the result is loaded. After reset the
// bitmap is swept to zero with s_tready low; cfg writes are taken during the
// sweep. If the receiver stalls, the result is held in the output register;
// the next item is accepted and processed, then waits for the held result.
`timescale 1ns / 1ps
`default_nettype none
`include "cumulative_ack_scoreboard_core_defines.svh"

module cumulative_ack_scoreboard_core
    import cas_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [10:0] segment_number, [15:11] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [10:0] cumulative_ack, [15:11] zero
    output logic [0:0]       m_tuser,   // [0] accepted
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data   // [10:0] segment_count
);

    cas_cmd_t         cmd;
    cas_status_t      status;
    logic [SEG_W-1:0] out_ack;
    logic             out_ok;

    assign cfg_ready = 1'b1;

    // controller
    cas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    cas_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_func   (s_tuser),
        .in_seg    (s_tdata[SEG_W-1:0]),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ack   (out_ack),
        .out_ok    (out_ok)
    );

    // output packing
    assign m_tdata = {5'b0, out_ack};
    assign m_tuser = out_ok;

    // checks
    `CAS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "busy accept")
    `CAS_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, status.out_free, "result lost")
    `CAS_ASSERT_IMP(a_sweep_blocks_input, clk, rst_n, cmd.sweep, !s_tready, "open in sweep")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the cumulative ack scoreboard core
`timescale 1ns / 1ps

module testbench;
    import cas_pkg::*;

    localparam int MAX_SEG        = MAX_SEGMENTS_DEF;
    localparam int RAND_PER_PHASE = 90;
    localparam int NUM_PHASES     = 8;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_TAIL     = 80;
    localparam int DIR_ROWS       = 31;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // one directed step: an item or a segment_count write
    typedef struct packed {
        row_kind_t   kind;
        cas_func_t   func;
        logic [10:0] value;
        bit          typed;
        logic [10:0] ack;
        logic        acc;
    } dir_row_t;

    typedef struct {
        logic [10:0] ack;
        logic        acc;
    } ack_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [10:0] segment_number, [15:11] zero
    logic [1:0]  s_tuser = '0;      // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [10:0] cumulative_ack, [15:11] zero
    logic [0:0]  m_tuser;           // [0] accepted
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;     // [10:0] segment_count

    // expectation typed in by the directed table, travels with the item
    bit          row_typed = 1'b0;
    logic [10:0] row_ack = '0;
    logic        row_acc = 1'b0;

    // shadow copy of the scoreboard
    bit [MAX_SEG-1:0] seen_segments = '0;
    int               ack_edge = 0;
    logic [10:0]      seg_limit = SEG_COUNT_RESET;

    ack_result_t pending_acks[$];

    int  error_count = 0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  acks_checked = 0;
    int  cfg_writes = 0;
    int  burst_left = 1;
    bit  hold_req = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b1, 11'd0, 1'b1},  // query right after reset
        '{ROW_ITEM, FUNC_MARK,  11'd0,    1'b1, 11'd0, 1'b0},  // segment zero is rejected
        '{ROW_ITEM, FUNC_MARK,  11'd1025, 1'b1, 11'd0, 1'b0},  // just above the bitmap
        '{ROW_ITEM, FUNC_MARK,  11'd2047, 1'b1, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_RSVD,  11'd2047, 1'b1, 11'd0, 1'b0},  // reserved code
        '{ROW_ITEM, FUNC_MARK,  11'd1,    1'b1, 11'd0, 1'b1},
        '{ROW_ITEM, FUNC_MARK,  11'd2,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd4,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b0, 11'd0, 1'b0},  // stops at the hole
        '{ROW_ITEM, FUNC_MARK,  11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd1024, 1'b0, 11'd0, 1'b0},  // last bit of the bitmap
        '{ROW_ITEM, FUNC_CLEAR, 11'd0,    1'b1, 11'd0, 1'b1},
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b1, 11'd0, 1'b1},
        '{ROW_CFG,  FUNC_MARK,  11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd1,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd2,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd4,    1'b1, 11'd0, 1'b0},  // above a small size
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b0, 11'd0, 1'b0},  // frontier hits the size
        '{ROW_CFG,  FUNC_MARK,  11'd2,    1'b0, 11'd0, 1'b0},  // shrink below frontier
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_CFG,  FUNC_MARK,  11'd0,    1'b0, 11'd0, 1'b0},  // empty bitmap size
        '{ROW_ITEM, FUNC_MARK,  11'd1,    1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_QUERY, 11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_CFG,  FUNC_MARK,  11'd2047, 1'b0, 11'd0, 1'b0},  // size above the parameter
        '{ROW_ITEM, FUNC_MARK,  11'd1024, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_MARK,  11'd1025, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM, FUNC_CLEAR, 11'd2047, 1'b1, 11'd0, 1'b1},
        '{ROW_CFG,  FUNC_MARK,  11'd1024, 1'b0, 11'd0, 1'b0}
    };

    cumulative_ack_scoreboard_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("timeout: %0d acks still outstanding", pending_acks.size());
        $display("cumulative_ack_scoreboard_core regression: fail");
        $finish;
    end

    // apply one item to the shadow scoreboard and return the expected ack
    function automatic void advance_scoreboard(input cas_func_t func, input logic [10:0] seg,
                                               output logic [10:0] ack, output logic acc);
        int eff;
        eff = (int'(seg_limit) > MAX_SEG) ? MAX_SEG : int'(seg_limit);
        acc = 1'b0;
        case (func)
            FUNC_MARK:
            begin
                if (seg >= 11'd1 && int'(seg) <= eff)
                begin
                    seen_segments[seg - 11'd1] = 1'b1;
                    acc = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                while (ack_edge < eff && seen_segments[ack_edge])
                    ack_edge++;
                acc = 1'b1;
            end
            FUNC_CLEAR:
            begin
                seen_segments = '0;
                ack_edge = 0;
                acc = 1'b1;
            end
            default:
                acc = 1'b0;
        endcase
        ack = ack_edge[10:0];
    endfunction

    // monitor: check results in order, predict each accepted item
    always @(posedge clk)
    begin
        ack_result_t want;
        ack_result_t guess;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_acks.size() == 0)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: ack %0d accepted %0b",
                                 m_tdata, m_tuser[0]);
                end
                else
                begin
                    want = pending_acks.pop_front();
                    acks_checked++;
                    if (m_tdata !== {5'b0, want.ack} || m_tuser[0] !== want.acc)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch on ack %0d: expected ack %0d accepted %0b, got ack %0d accepted %0b",
                                     acks_checked, want.ack, want.acc, m_tdata, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_scoreboard(cas_func_t'(s_tuser), s_tdata[10:0], guess.ack, guess.acc);
                if (row_typed)
                begin
                    guess.ack = row_ack;
                    guess.acc = row_acc;
                end
                pending_acks.push_back(guess);
            end
        end
    end

    // receiver: stall pattern of its own, plus one long hold on request
    initial
    begin
        int rx_mode;
        int rx_left;
        int rx_tick;
        rx_mode = 0;
        rx_left = 0;
        rx_tick = 0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(20, 120);
                end
                rx_left--;
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((rx_tick % 3) != 0);
                endcase
            end
        end
    end

    // offer one item and wait for its transfer, then maybe idle
    task automatic offer_segment(input cas_func_t func, input logic [10:0] seg, input bit typed,
                                 input logic [10:0] t_ack, input logic t_acc);
        int gap;
        s_tvalid  <= 1'b1;
        s_tdata   <= {5'b0, seg};
        s_tuser   <= func;
        row_typed <= typed;
        row_ack   <= t_ack;
        row_acc   <= t_acc;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop sending until every outstanding ack has come back
    task automatic wait_all_acks();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_acks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // segment_count write, only with the block idle
    task automatic write_seg_limit(input logic [10:0] value);
        wait_all_acks();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        seg_limit = value;
        cfg_writes++;
    endtask

    // stimulus
    initial
    begin
        int          phase_sizes [NUM_PHASES];
        int          eff;
        int          cursor;
        int          r;
        logic [10:0] seg;
        cas_func_t   func;

        phase_sizes = '{1024, 37, 1, 0, 2047, 16, 1024, 2};
        phase_sizes[7] = $urandom_range(2, 64);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_seg_limit(dir_rows[i].value);
            else
                offer_segment(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed,
                              dir_rows[i].ack, dir_rows[i].acc);
        end

        // random phases, one segment_count setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_seg_limit(phase_sizes[p][10:0]);
            eff = (phase_sizes[p] > MAX_SEG) ? MAX_SEG : phase_sizes[p];
            cursor = 1;
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                // long receiver hold while items keep coming
                if (p == 0 && k == 30)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                seg = 11'd0;
                if (r < 55)
                begin
                    // mostly in-order marks near the frontier
                    func = FUNC_MARK;
                    seg = 11'(cursor + $urandom_range(0, 3));
                    if ($urandom_range(0, 2) != 0)
                        cursor++;
                    if (cursor > eff + 1)
                        cursor = 1;
                end
                else if (r < 70)
                    func = FUNC_QUERY;
                else if (r < 80)
                begin
                    func = FUNC_MARK;
                    seg = 11'($urandom_range(0, 2047));
                end
                else if (r < 85)
                begin
                    // size boundary
                    func = FUNC_MARK;
                    case ($urandom_range(0, 2))
                        0: seg = 11'd0;
                        1: seg = 11'(eff);
                        default: seg = 11'(eff + 1);
                    endcase
                end
                else if (r < 90)
                begin
                    func = FUNC_RSVD;
                    seg = 11'($urandom_range(0, 2047));
                end
                else if (r < 93)
                begin
                    func = FUNC_CLEAR;
                    seg = 11'($urandom_range(0, 2047));
                    cursor = 1;
                end
                else
                    func = FUNC_QUERY;
                offer_segment(func, seg, 1'b0, 11'd0, 1'b0);
            end
        end

        wait_all_acks();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d items (%0d directed rows) over %0d segment_count writes",
                 items_sent, DIR_ROWS, cfg_writes);
        $display("checked %0d acks, %0d mismatches, %0d left outstanding",
                 acks_checked, mismatch_count, pending_acks.size());
        if (error_count == 0 && pending_acks.size() == 0)
            $display("cumulative_ack_scoreboard_core regression: pass");
        else
            $display("cumulative_ack_scoreboard_core regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/cas_pkg.sv
src/cas_ctrl.sv
src/cas_datapath.sv
src/cumulative_ack_scoreboard_core.sv
tb/testbench.sv
